// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication to the next cycle, skipped while reset is high.
`define TPC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("clipper port check failed");

// Implication to the next cycle, checked during reset too.
`define TPC_ASSERT_ALWAYS(name, pre, post) \
  name: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("clipper reset check failed");

`endif

// ===== rtl/tpc_pkg.sv =====
`default_nettype none
package tpc_pkg;

  localparam int DW   = 67;        // exact plane distance
  localparam int DENW = DW + 1;    // positive divisor d_a - d_b
  localparam int REMW = DW + 2;    // shifted partial remainder
  localparam int TW   = 24;        // edge parameter, Q0.24
  localparam int RELW = 33;        // vertex minus point, or b - a
  localparam int PRW  = RELW + 32; // normal times offset
  localparam int IPW  = RELW + TW + 1;

  typedef logic signed [31:0] q_t;
  typedef logic signed [DW-1:0] dist_t;
  typedef logic [DENW-1:0] den_t;
  typedef logic [REMW-1:0] rem_t;
  typedef logic [TW-1:0] frac_t;
  typedef logic [2:0] cfg_idx_t;
  typedef logic [1:0] kind_t;

  localparam cfg_idx_t REG_PP_X = 3'd0;
  localparam cfg_idx_t REG_PP_Y = 3'd1;
  localparam cfg_idx_t REG_PP_Z = 3'd2;
  localparam cfg_idx_t REG_PN_X = 3'd3;
  localparam cfg_idx_t REG_PN_Y = 3'd4;
  localparam cfg_idx_t REG_PN_Z = 3'd5;

  localparam q_t PN_Z_RESET = 32'sd65536;

  // Number of inside vertices.
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_ONE  = 2'd1;
  localparam kind_t KIND_TWO  = 2'd2;
  localparam kind_t KIND_ALL  = 2'd3;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vtx_t;

  typedef struct packed {
    q_t a_x;
    q_t a_y;
    q_t a_z;
    q_t b_x;
    q_t b_y;
    q_t b_z;
    q_t c_x;
    q_t c_y;
    q_t c_z;
    logic [31:0] color;
  } tri_in_t;

  typedef struct packed {
    q_t out_a_x;
    q_t out_a_y;
    q_t out_a_z;
    q_t out_b_x;
    q_t out_b_y;
    q_t out_b_z;
    q_t out_c_x;
    q_t out_c_y;
    q_t out_c_z;
    logic [31:0] out_color;
    logic last_of_run;
  } tri_out_t;

  // Both edge crossings of a request, carried side by side through the divider.
  typedef struct packed {
    kind_t kind;
    tri_in_t trig;
    vtx_t vin0;
    vtx_t vin1;
    vtx_t [1:0] va;
    vtx_t [1:0] vb;
    den_t [1:0] den;
    rem_t [1:0] rem;
    frac_t [1:0] t;
  } clip_t;

  function automatic vtx_t tri_vtx(tri_in_t tr, logic [1:0] i);
    vtx_t v;
    case (i)
      2'd0: v = {tr.a_x, tr.a_y, tr.a_z};
      2'd1: v = {tr.b_x, tr.b_y, tr.b_z};
      default: v = {tr.c_x, tr.c_y, tr.c_z};
    endcase
    return v;
  endfunction

  function automatic q_t vtx_axis(vtx_t v, logic [1:0] k);
    q_t r;
    case (k)
      2'd0: r = v.x;
      2'd1: r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic tri_out_t make_out(vtx_t p0, vtx_t p1, vtx_t p2,
                                        logic [31:0] color, logic last);
    tri_out_t o;
    o = {p0.x, p0.y, p0.z, p1.x, p1.y, p1.z, p2.x, p2.y, p2.z, color, last};
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpc_dist.sv =====
`default_nettype none
module tpc_dist import tpc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire tri_in_t in_tri,
  input  wire vtx_t    plane_p,
  input  wire vtx_t    plane_n,
  output logic         out_valid,
  output tri_in_t      out_tri,
  output dist_t [2:0]  dists
);

  logic valid1, valid2;
  tri_in_t tri_s1, tri_s2;
  logic signed [RELW-1:0] rel1 [3][3];
  logic signed [PRW-1:0] prod2 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1 <= in_valid;
      valid2 <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    tri_s1 <= in_tri;
    tri_s2 <= tri_s1;
    out_tri <= tri_s2;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rel1[i][k] <= RELW'(vtx_axis(tri_vtx(in_tri, 2'(i)), 2'(k)))
                    - RELW'(vtx_axis(plane_p, 2'(k)));
        prod2[i][k] <= PRW'(rel1[i][k]) * PRW'(vtx_axis(plane_n, 2'(k)));
      end
      dists[i] <= DW'(prod2[i][0]) + DW'(prod2[i][1]) + DW'(prod2[i][2]);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpc_div_step.sv =====
`default_nettype none
module tpc_div_step import tpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire clip_t d_in,
  output logic       out_valid,
  output clip_t      d_out
);

  clip_t nxt;
  rem_t  r2 [2];

  // One restoring quotient bit per crossing.
  always_comb begin
    nxt = d_in;
    for (int j = 0; j < 2; j++) begin
      r2[j] = {d_in.rem[j][REMW-2:0], 1'b0};
      if (r2[j] >= REMW'(d_in.den[j])) begin
        nxt.rem[j] = r2[j] - REMW'(d_in.den[j]);
        nxt.t[j] = {d_in.t[j][TW-2:0], 1'b1};
      end else begin
        nxt.rem[j] = r2[j];
        nxt.t[j] = {d_in.t[j][TW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/tpc_interp.sv =====
`default_nettype none
module tpc_interp import tpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire clip_t c,
  output logic       out_valid,
  output kind_t      kind,
  output tri_in_t    trig,
  output vtx_t       vin0,
  output vtx_t       vin1,
  output vtx_t       x0,
  output vtx_t       x1
);

  typedef struct packed {
    kind_t kind;
    tri_in_t trig;
    vtx_t vin0;
    vtx_t vin1;
  } side_t;

  logic valid_a, valid_b;
  side_t side_a, side_b, side_c;
  vtx_t [1:0] va_a, va_b;
  frac_t t_a [2];
  logic signed [RELW-1:0] diff_a [2][3];
  logic signed [IPW-1:0] prod_b [2][3];
  logic signed [IPW-1:0] sh [2][3];
  q_t xr [2][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        sh[j][k] = prod_b[j][k] >>> TW;  // floor
      end
    end
  end

  always_ff @(posedge clk) begin
    side_a <= {c.kind, c.trig, c.vin0, c.vin1};
    side_b <= side_a;
    side_c <= side_b;
    va_a <= c.va;
    va_b <= va_a;
    for (int j = 0; j < 2; j++) begin
      t_a[j] <= c.t[j];
      for (int k = 0; k < 3; k++) begin
        diff_a[j][k] <= RELW'(vtx_axis(c.vb[j], 2'(k)))
                      - RELW'(vtx_axis(c.va[j], 2'(k)));
        prod_b[j][k] <= IPW'(diff_a[j][k]) * $signed(IPW'(t_a[j]));
        xr[j][k] <= vtx_axis(va_b[j], 2'(k)) + $signed(sh[j][k][31:0]);
      end
    end
  end

  assign kind = side_c.kind;
  assign trig = side_c.trig;
  assign vin0 = side_c.vin0;
  assign vin1 = side_c.vin1;
  assign x0 = {xr[0][0], xr[0][1], xr[0][2]};
  assign x1 = {xr[1][0], xr[1][1], xr[1][2]};

endmodule
`default_nettype wire

// ===== rtl/triangle_plane_clipper.sv =====
// Triangle clipper against one plane. A request (three Q16.16 vertices and a
// color word) is taken when start is high and busy is low; busy then stays
// high for exactly one cycle, during which no request is taken. The result
// port delivers up to two triangles per request, one per cycle. The path
// from request to first result has 3 distance stages, 1 select stage, 24
// divider stages (one quotient bit each), 3 interpolation stages and 1 output
// register. A request with no inside vertex yields nothing. The receiver
// cannot stall: result_valid pulses for one cycle per triangle, last_of_run
// marks the final triangle of a request, and the two triangles of a quad
// arrive in adjacent cycles. Plane registers are written over the cfg port
// (always ready) and must only change while no request is in flight.
`default_nettype none
module triangle_plane_clipper import tpc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire tri_in_t  tri_in,
  output logic          result_valid,
  output tri_out_t      tri_out,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire cfg_idx_t cfg_index,
  input  wire q_t       cfg_data
);

  // plane registers
  vtx_t plane_p, plane_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_p <= '0;
      plane_n <= {32'sd0, 32'sd0, PN_Z_RESET};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PP_X: plane_p.x <= cfg_data;
        REG_PP_Y: plane_p.y <= cfg_data;
        REG_PP_Z: plane_p.z <= cfg_data;
        REG_PN_X: plane_n.x <= cfg_data;
        REG_PN_Y: plane_n.y <= cfg_data;
        REG_PN_Z: plane_n.z <= cfg_data;
        default: ;  // unused index: dropped
      endcase
    end
  end

  // intake: a request is taken when start is high and busy is low
  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= accept;
    end
  end

  // stages 1-3: signed distances
  logic d_valid;
  tri_in_t d_tri;
  dist_t [2:0] vdist;

  tpc_dist u_dist (
    .clk(clk), .rst(rst),
    .in_valid(accept), .in_tri(tri_in),
    .plane_p(plane_p), .plane_n(plane_n),
    .out_valid(d_valid), .out_tri(d_tri), .dists(vdist)
  );

  // stage 4: classify vertices, pick the two crossing edges
  logic [2:0] in_mask;
  logic [1:0] ins0, ins1, outs0, outs1;
  logic [1:0] ea0, eb0, ea1, eb1;
  kind_t kind;
  clip_t sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mask[i] = ~vdist[i][DW-1];
    end
    ins0 = 2'd0;
    ins1 = 2'd1;
    outs0 = 2'd1;
    outs1 = 2'd2;
    case (in_mask)
      3'b001: begin ins0 = 2'd0; outs0 = 2'd1; outs1 = 2'd2; end
      3'b010: begin ins0 = 2'd1; outs0 = 2'd0; outs1 = 2'd2; end
      3'b100: begin ins0 = 2'd2; outs0 = 2'd0; outs1 = 2'd1; end
      3'b011: begin ins0 = 2'd0; ins1 = 2'd1; outs0 = 2'd2; end
      3'b101: begin ins0 = 2'd0; ins1 = 2'd2; outs0 = 2'd1; end
      3'b110: begin ins0 = 2'd1; ins1 = 2'd2; outs0 = 2'd0; end
      default: ;  // nothing to cross
    endcase
    case ($countones(in_mask))
      0: kind = KIND_NONE;
      1: kind = KIND_ONE;
      2: kind = KIND_TWO;
      default: kind = KIND_ALL;
    endcase
    // one inside: both edges leave I0; two inside: both edges reach O0
    ea0 = ins0;
    eb0 = outs0;
    ea1 = (kind == KIND_TWO) ? ins1 : ins0;
    eb1 = (kind == KIND_TWO) ? outs0 : outs1;

    sel.kind = kind;
    sel.trig = d_tri;
    sel.vin0 = tri_vtx(d_tri, ins0);
    sel.vin1 = tri_vtx(d_tri, ins1);
    sel.va[0] = tri_vtx(d_tri, ea0);
    sel.vb[0] = tri_vtx(d_tri, eb0);
    sel.va[1] = tri_vtx(d_tri, ea1);
    sel.vb[1] = tri_vtx(d_tri, eb1);
    sel.den[0] = DENW'(vdist[ea0]) - DENW'(vdist[eb0]);
    sel.den[1] = DENW'(vdist[ea1]) - DENW'(vdist[eb1]);
    sel.rem[0] = REMW'(vdist[ea0]);
    sel.rem[1] = REMW'(vdist[ea1]);
    sel.t = '0;
  end

  logic chain_valid [TW+1];
  clip_t chain [TW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else begin
      chain_valid[0] <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    chain[0] <= sel;
  end

  // t = d_a / (d_a - d_b), one bit per stage
  for (genvar g = 0; g < TW; g++) begin : g_div
    tpc_div_step u_step (
      .clk(clk), .rst(rst),
      .in_valid(chain_valid[g]), .d_in(chain[g]),
      .out_valid(chain_valid[g+1]), .d_out(chain[g+1])
    );
  end

  // crossing points
  logic f_valid;
  kind_t f_kind;
  tri_in_t f_tri;
  vtx_t f_vin0, f_vin1, f_x0, f_x1;

  tpc_interp u_interp (
    .clk(clk), .rst(rst),
    .in_valid(chain_valid[TW]), .c(chain[TW]),
    .out_valid(f_valid), .kind(f_kind), .trig(f_tri),
    .vin0(f_vin0), .vin1(f_vin1), .x0(f_x0), .x1(f_x1)
  );

  // output: first triangle now, the second of a quad next cycle
  logic pend_valid;
  tri_out_t pend;
  tri_out_t first;

  always_comb begin
    case (f_kind)
      KIND_ONE: first = make_out(f_vin0, f_x0, f_x1, f_tri.color, 1'b1);
      KIND_TWO: first = make_out(f_vin0, f_vin1, f_x0, f_tri.color, 1'b0);
      default: first = make_out(tri_vtx(f_tri, 2'd0), tri_vtx(f_tri, 2'd1),
                                tri_vtx(f_tri, 2'd2), f_tri.color, 1'b1);
    endcase
  end

  // busy blocks back-to-back requests, so a pending triangle never meets a new one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (f_valid && f_kind != KIND_NONE) begin
      result_valid <= 1'b1;
      pend_valid <= (f_kind == KIND_TWO);
    end else begin
      result_valid <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid) begin
      tri_out <= first;
      pend <= make_out(f_vin1, f_x0, f_x1, f_tri.color, 1'b1);
    end else if (pend_valid) begin
      tri_out <= pend;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module tpc_checker import tpc_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     result_valid,
  input wire tri_out_t tri_out
);

  `TPC_ASSERT_NEXT(a_busy_after_req, start && !busy, busy)
  `TPC_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
  `TPC_ASSERT_NEXT(a_quad_pair, result_valid && !tri_out.last_of_run, result_valid && tri_out.last_of_run)
  `TPC_ASSERT_ALWAYS(a_reset_quiet, rst, !busy && !result_valid)

endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (.*);
`default_nettype wire
